// ----- rtl/fxalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared opcodes, widths and the word type that flows down the ALU cell chain.
// ----------------------------------------------------------------------------
package fxalu_pkg;

   localparam int DataWidthDefault = 32;
   localparam int FracBitsDefault  = 8;
   localparam int CmdWidth         = 4;

   typedef enum logic [CmdWidth-1:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_LT      = 4'd5,
      OP_GE      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } cmd_type;

   // control carried alongside the data through the chain
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
      logic    negate;
      logic    div_zero;
   } ctrl_type;

endpackage

// ----- rtl/fxalu_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_div_cell
// One restoring-division step: shifts in one dividend bit, conditionally
// subtracts the divisor and shifts the quotient bit in. Registered output,
// held while enable is low.
// ----------------------------------------------------------------------------
module fxalu_div_cell #(
   parameter int DW = 32,
   parameter int NW = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  fxalu_pkg::ctrl_type    ctrl_i,
   input  logic [NW-1:0]          num_i,
   input  logic [DW-1:0]          den_i,
   input  logic [DW:0]            rem_i,
   input  logic [DW-1:0]          res_i,
   output fxalu_pkg::ctrl_type    ctrl_o,
   output logic [NW-1:0]          num_o,
   output logic [DW-1:0]          den_o,
   output logic [DW:0]            rem_o,
   output logic [DW-1:0]          res_o
);
   import fxalu_pkg::*;

   ctrl_type        ctrl_ff;
   logic [NW-1:0]   num_ff, num_in;
   logic [DW-1:0]   den_ff;
   logic [DW:0]     rem_ff, rem_in;
   logic [DW-1:0]   res_ff, res_in;
   logic [DW+1:0]   trial;
   logic [DW+1:0]   shifted;

   // one step, active only for divide words
   always_comb begin
      shifted = {rem_i, num_i[NW-1]};
      trial   = shifted - {2'b00, den_i};
      num_in  = {num_i[NW-2:0], 1'b0};
      rem_in  = rem_i;
      res_in  = res_i;
      if (ctrl_i.cmd == OP_DIV) begin
         if (!trial[DW+1]) begin
            rem_in = trial[DW:0];
            res_in = {res_i[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW:0];
            res_in = {res_i[DW-2:0], 1'b0};
         end
      end
   end

   // stage register, frozen while the chain stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_i.valid;
      end
      if (enable) begin
         ctrl_ff.cmd      <= ctrl_i.cmd;
         ctrl_ff.negate   <= ctrl_i.negate;
         ctrl_ff.div_zero <= ctrl_i.div_zero;
         num_ff <= num_in;
         den_ff <= den_i;
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign num_o  = num_ff;
   assign den_o  = den_ff;
   assign rem_o  = rem_ff;
   assign res_o  = res_ff;
endmodule

// ----- rtl/fxalu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_front
// Entry stage: decodes the word, computes the simple operations and the
// full 32x32 product, and prepares the divider operands.
// ----------------------------------------------------------------------------
module fxalu_front #(
   parameter int DW = 32,
   parameter int FB = 8,
   parameter int NW = DW + FB
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         valid_i,
   input  fxalu_pkg::cmd_type           cmd_i,
   input  logic signed [DW-1:0]         a_i,
   input  logic signed [DW-1:0]         b_i,
   output fxalu_pkg::ctrl_type          ctrl_o,
   output logic [NW-1:0]                num_o,
   output logic [DW-1:0]                den_o,
   output logic [DW-1:0]                res_o,
   output logic                         cmp_o,
   output logic signed [2*DW-1:0]       prod_o
);
   import fxalu_pkg::*;

   ctrl_type              ctrl_ff, ctrl_in;
   logic [NW-1:0]         num_ff;
   logic [DW-1:0]         den_ff;
   logic [DW-1:0]         res_ff, res_in;
   logic                  cmp_ff, cmp_in;
   logic signed [2*DW-1:0] prod_ff;
   logic [DW-1:0]         mag_a, mag_b;
   logic                  a_lt_b, b_lt_a;

   assign mag_a  = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
   assign mag_b  = b_i[DW-1] ? DW'(-b_i) : DW'(b_i);
   assign a_lt_b = a_i < b_i;
   assign b_lt_a = b_i < a_i;

   // results of the simple operations
   always_comb begin
      res_in = '0;
      cmp_in = 1'b0;
      case (cmd_i)
         OP_ADD:     res_in = DW'(a_i + b_i);
         OP_SUB:     res_in = DW'(a_i - b_i);
         OP_GT:      cmp_in = b_lt_a;
         OP_LT:      cmp_in = a_lt_b;
         OP_GE:      cmp_in = !a_lt_b;
         OP_LE:      cmp_in = !b_lt_a;
         OP_EQ:      cmp_in = (a_i == b_i);
         OP_NE:      cmp_in = (a_i != b_i);
         OP_MIN:     res_in = a_lt_b ? a_i : b_i;
         OP_MAX:     res_in = b_lt_a ? a_i : b_i;
         OP_INC:     res_in = DW'(a_i + 1'b1);
         OP_DEC:     res_in = DW'(a_i - 1'b1);
         OP_TOINT:   res_in = DW'(a_i >>> FB);
         OP_FROMINT: res_in = DW'(a_i <<< FB);
         default:    res_in = '0;
      endcase
      ctrl_in.valid    = valid_i;
      ctrl_in.cmd      = cmd_i;
      ctrl_in.negate   = a_i[DW-1] ^ b_i[DW-1];
      ctrl_in.div_zero = (cmd_i == OP_DIV) && (b_i == '0);
   end

   // entry register, frozen while the chain stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (enable) begin
         ctrl_ff.cmd      <= ctrl_in.cmd;
         ctrl_ff.negate   <= ctrl_in.negate;
         ctrl_ff.div_zero <= ctrl_in.div_zero;
         num_ff  <= NW'(mag_a) << FB;
         den_ff  <= mag_b;
         res_ff  <= res_in;
         cmp_ff  <= cmp_in;
         prod_ff <= a_i * b_i;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign num_o  = num_ff;
   assign den_o  = den_ff;
   assign res_o  = res_ff;
   assign cmp_o  = cmp_ff;
   assign prod_o = prod_ff;
endmodule

// ----- rtl/fixed_point_q24_8_alu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// Signed Q24.8 fixed-point ALU with a fully pipelined divider cell chain.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless stalled and returns each result in order,
// after it passes one entry stage, one restoring-division cell per quotient
// bit of the shifted dividend, and the output register. All other operations
// ride the same chain so results stay ordered. The chain advances only when
// the output register is free or being taken, so rsp_ready low with a result
// waiting freezes the whole pipe and drops req_ready in the same cycle.
module fixed_point_q24_8_alu_unit #(
   parameter int DATA_WIDTH = fxalu_pkg::DataWidthDefault,
   parameter int FRAC_BITS  = fxalu_pkg::FracBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fxalu_pkg::CmdWidth-1:0] req_cmd,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]  rsp_value,
   output logic                          rsp_compare_true,
   output logic                          rsp_divide_by_zero
);
   import fxalu_pkg::*;

   localparam int NW = DATA_WIDTH + FRAC_BITS;
   localparam int NC = NW;

   // whole-chain enable: every stage moves only when the output slot
   // can absorb a word
   logic advance;

   ctrl_type               f_ctrl;
   logic [NW-1:0]          f_num;
   logic [DATA_WIDTH-1:0]  f_den, f_res;
   logic                   f_cmp;
   logic signed [2*DATA_WIDTH-1:0] f_prod;

   ctrl_type               c_ctrl [NC+1];
   logic [NW-1:0]          c_num  [NC+1];
   logic [DATA_WIDTH-1:0]  c_den  [NC+1];
   logic [DATA_WIDTH:0]    c_rem  [NC+1];
   logic [DATA_WIDTH-1:0]  c_res  [NC+1];

   // side-band delay line for non-divide results
   logic [DATA_WIDTH-1:0]  side_ff [NC];
   logic                   sidec_ff [NC];

   logic                   out_valid_ff;
   logic [DATA_WIDTH-1:0]  out_value_ff, out_value_in;
   logic                   out_cmp_ff;
   logic                   out_dz_ff;
   logic signed [2*DATA_WIDTH-1:0] prod_sh;
   logic [DATA_WIDTH-1:0]  mul_ff [NC];

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   fxalu_front #(.DW(DATA_WIDTH), .FB(FRAC_BITS), .NW(NW)) u_front (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .valid_i(req_valid && advance),
      .cmd_i  (cmd_type'(req_cmd)),
      .a_i    (req_operand_a),
      .b_i    (req_operand_b),
      .ctrl_o (f_ctrl),
      .num_o  (f_num),
      .den_o  (f_den),
      .res_o  (f_res),
      .cmp_o  (f_cmp),
      .prod_o (f_prod)
   );

   assign c_ctrl[0] = f_ctrl;
   assign c_num[0]  = f_num;
   assign c_den[0]  = f_den;
   assign c_rem[0]  = '0;
   assign c_res[0]  = '0;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      fxalu_div_cell #(.DW(DATA_WIDTH), .NW(NW)) u_cell (
         .clock (clock),
         .reset (reset),
         .enable(advance),
         .ctrl_i(c_ctrl[i]),
         .num_i (c_num[i]),
         .den_i (c_den[i]),
         .rem_i (c_rem[i]),
         .res_i (c_res[i]),
         .ctrl_o(c_ctrl[i+1]),
         .num_o (c_num[i+1]),
         .den_o (c_den[i+1]),
         .rem_o (c_rem[i+1]),
         .res_o (c_res[i+1])
      );
   end

   assign prod_sh = f_prod >>> FRAC_BITS;

   // side results travel beside the cells, stalling with them
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0]  <= f_res;
         sidec_ff[0] <= f_cmp;
         mul_ff[0]   <= prod_sh[DATA_WIDTH-1:0];
         for (int k = 1; k < NC; k++) begin
            side_ff[k]  <= side_ff[k-1];
            sidec_ff[k] <= sidec_ff[k-1];
            mul_ff[k]   <= mul_ff[k-1];
         end
      end
   end

   // final select and sign fix of the quotient
   always_comb begin
      case (c_ctrl[NC].cmd)
         OP_MUL:  out_value_in = mul_ff[NC-1];
         OP_DIV: begin
            if (c_ctrl[NC].div_zero) begin
               out_value_in = '0;
            end else begin
               out_value_in = c_ctrl[NC].negate ? DATA_WIDTH'(-c_res[NC]) : c_res[NC];
            end
         end
         default: out_value_in = side_ff[NC-1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= c_ctrl[NC].valid;
      end
      if (advance) begin
         out_value_ff <= out_value_in;
         out_cmp_ff   <= sidec_ff[NC-1];
         out_dz_ff    <= c_ctrl[NC].div_zero;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value          = out_value_ff;
   assign rsp_compare_true   = out_cmp_ff;
   assign rsp_divide_by_zero = out_dz_ff;

   // flags are exclusive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_compare_true && rsp_divide_by_zero))
      else $error("compare and divide flags both set");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_value == '0)
      else $error("divide by zero gave nonzero value");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("held result changed");
endmodule

// ----- tb/fixed_point_q24_8_alu_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit_tb
// Self-checking bench for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
// A short directed table covers every opcode, operand extremes, divide by
// zero and a min tie. Random words follow, mixing full-range operands
// with small ones, under several idle/stall phases. Every result word is
// checked against an in-bench ALU model through an in-order queue.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_unit_tb;
   import fxalu_pkg::*;

   localparam int FB = 8;
   localparam int LATENCY = 42;
   localparam int RAND_ITEMS = 900;

   typedef struct packed {
      logic signed [31:0] value;
      logic               cmp;
      logic               dz;
   } alu_out_type;

   typedef struct {
      cmd_type            cmd;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               has_exp;
      alu_out_type        exp_out;
   } vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CmdWidth-1:0] req_cmd = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_value;
   logic rsp_compare_true;
   logic rsp_divide_by_zero;

   alu_out_type pending_results[$];
   int       errors = 0;
   int       sent = 0;
   int       received = 0;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;

   fixed_point_q24_8_alu_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_value(rsp_value),
      .rsp_compare_true(rsp_compare_true), .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected ALU result for one word
   function automatic alu_out_type alu_predict(cmd_type cmd, logic signed [31:0] a,
                                               logic signed [31:0] b);
      alu_out_type r;
      logic signed [63:0] prod;
      logic signed [63:0] num;
      logic signed [63:0] quo;
      r = '0;
      prod = 64'(a) * 64'(b);
      num = 64'(a) <<< FB;
      case (cmd)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: r.value = 32'(prod >>> FB);
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               quo = num / 64'(b);
               r.value = 32'(quo);
            end
         end
         OP_GT: r.cmp = a > b;
         OP_LT: r.cmp = a < b;
         OP_GE: r.cmp = a >= b;
         OP_LE: r.cmp = a <= b;
         OP_EQ: r.cmp = a == b;
         OP_NE: r.cmp = a != b;
         OP_MIN: r.value = (a < b) ? a : b;
         OP_MAX: r.value = (b < a) ? a : b;
         OP_INC: r.value = a + 32'sd1;
         OP_DEC: r.value = a - 32'sd1;
         OP_TOINT: r.value = a >>> FB;
         default: r.value = a <<< FB;
      endcase
      return r;
   endfunction

   // random operand: full range, small, or an extreme
   function automatic logic signed [31:0] pick_operand();
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) return $urandom;
      if (k < 8) return $signed(32'($urandom_range(0, 4096))) - 32'sd2048;
      case ($urandom_range(0, 4))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd256;
      endcase
   endfunction

   // send one word, holding valid until accepted
   task automatic send_word(cmd_type cmd, logic signed [31:0] a, logic signed [31:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(alu_predict(cmd, a, b));
      sent++;
   endtask

   // result side: random stall and check
   always @(posedge clock) begin
      alu_out_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            received++;
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_value !== e.value) begin
                  $error("value exp %h got %h", e.value, rsp_value);
                  errors++;
               end
               if (rsp_compare_true !== e.cmp) begin
                  $error("compare_true exp %b got %b", e.cmp, rsp_compare_true);
                  errors++;
               end
               if (rsp_divide_by_zero !== e.dz) begin
                  $error("divide_by_zero exp %b got %b", e.dz, rsp_divide_by_zero);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("fixed_point_q24_8_alu_unit_tb: errors");
      $finish;
   end

   initial begin
      vec_type dir_table[$];
      vec_type v;
      alu_out_type got;
      int n;
      int phase;
      int wait_cycles;
      cmd_type c;

      // directed rows; expected typed in where obvious
      dir_table = '{
         '{OP_ADD, 32'sh7fffffff, 32'sd1, 1'b1, '{32'sh80000000, 1'b0, 1'b0}},
         '{OP_SUB, 32'sh80000000, 32'sd1, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
         '{OP_MUL, 32'sh7fffffff, 32'sh7fffffff, 1'b0, '0},
         '{OP_MUL, 32'sh80000000, 32'sh80000000, 1'b0, '0},
         '{OP_MUL, -32'sd1, 32'sd1, 1'b1, '{-32'sd1, 1'b0, 1'b0}},
         '{OP_DIV, 32'sd1234, 32'sd0, 1'b1, '{32'sd0, 1'b0, 1'b1}},
         '{OP_DIV, 32'sh80000000, -32'sd1, 1'b0, '0},
         '{OP_DIV, -32'sd768, 32'sd512, 1'b0, '0},
         '{OP_GT, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sd0, 1'b0, 1'b0}},
         '{OP_LT, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sd0, 1'b1, 1'b0}},
         '{OP_GE, 32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b1, 1'b0}},
         '{OP_LE, 32'sd6, 32'sd5, 1'b1, '{32'sd0, 1'b0, 1'b0}},
         '{OP_EQ, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 1'b1, 1'b0}},
         '{OP_NE, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 1'b0, 1'b0}},
         '{OP_MIN, 32'sd7, 32'sd7, 1'b1, '{32'sd7, 1'b0, 1'b0}},
         '{OP_MAX, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
         '{OP_INC, 32'sh7fffffff, 32'sd9, 1'b1, '{32'sh80000000, 1'b0, 1'b0}},
         '{OP_DEC, 32'sh80000000, 32'sd9, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
         '{OP_TOINT, -32'sd1, 32'sd0, 1'b1, '{-32'sd1, 1'b0, 1'b0}},
         '{OP_TOINT, 32'sh7fffffff, 32'sd0, 1'b1, '{32'sh007fffff, 1'b0, 1'b0}},
         '{OP_FROMINT, 32'sh7fffffff, -32'sd1, 1'b1, '{-32'sd256, 1'b0, 1'b0}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_table[i]) begin
         v = dir_table[i];
         if (v.has_exp) begin
            got = alu_predict(v.cmd, v.a, v.b);
            if (got !== v.exp_out) begin
               $error("model row %0d exp %h got %h", i, v.exp_out, got);
               errors++;
            end
         end
         send_word(v.cmd, v.a, v.b);
      end

      // random words over idle/stall phases
      n = 0;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            3: begin send_idle_pct = 27; recv_stall_pct = 27; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         repeat (RAND_ITEMS / 5) begin
            c = cmd_type'($urandom_range(0, 15));
            if (c == OP_DIV && $urandom_range(0, 19) == 0)
               send_word(c, pick_operand(), 32'sd0);
            else
               send_word(c, pick_operand(), pick_operand());
            n++;
         end
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;

      // drain
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         errors++;
      end

      $display("covered %0d words (%0d random) over every opcode, %0d results checked",
               sent, n, received);
      if (errors == 0)
         $display("fixed_point_q24_8_alu_unit_tb: clean");
      else
         $display("fixed_point_q24_8_alu_unit_tb: errors");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/fxalu_pkg.sv
rtl/fxalu_div_cell.sv
rtl/fxalu_front.sv
rtl/fixed_point_q24_8_alu_unit.sv
tb/fixed_point_q24_8_alu_unit_tb.sv
